// ===== hdl/sha256_pkg.sv =====
// Shared types, constants and functions for the SHA-256 hasher.
package sha256_pkg;

    localparam int WORD_W = 32;
    localparam int COUNT_W = 61;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } req_t;

    typedef struct packed {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } rsp_t;

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        begin
            case (r)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

    function automatic word_t init_hash(input logic [2:0] i);
        word_t h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = '0;
            endcase
            return h;
        end
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

// ===== hdl/sha256_if.sv =====
// Valid/ready channel carrying one request or one response.
interface sha256_req_if;
    import sha256_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha256_rsp_if;
    import sha256_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/sha256_round.sv =====
// One SHA-256 round step, taking the schedule word as input, shared over all 64 rounds.
module sha256_round
    import sha256_pkg::*;
(
    input  word_t       a, b, c, d, e, f, g, h,
    input  word_t       wv,
    input  logic [5:0]  r,
    output word_t       new_a,
    output word_t       new_e
);
    word_t s0, s1, ch, maj, t1, t2;
    always_comb
    begin
        s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch = (e & f) ^ (~e & g);
        t1 = h + s1 + ch + round_k(r) + wv;
        s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        maj = (a & b) ^ (a & c) ^ (b & c);
        t2 = s0 + maj;
        new_a = t1 + t2;
        new_e = d + t1;
    end
endmodule

// ===== hdl/sha256_message_hasher_unit.sv =====
// Top level: byte-fed SHA-256 hasher with padding and digest output.
//
//  channel   | dir | payload
//  ----------+-----+------------------------------------------
//  req       | in  | data_byte, has_byte, end_of_message
//  rsp       | out | digest_word, word_index, last_word
//
// A byte that does not finish a block or the message is simply stored. A block-completing
// byte starts the 64 rounds, then a fold into the hash; one round
// unit runs each round in one cycle. End of message adds one or two
// padded blocks, then the 8 digest words on rsp, stalled by rsp.ready.
// Reset: asynchronous, hash at initial values, block buffer zero.
module sha256_message_hasher_unit
    import sha256_pkg::*;
(
    input logic clk,
    input logic rst_n,
    sha256_req_if.sink   req,
    sha256_rsp_if.source rsp
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_FOLD  = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    word_t hash_reg [8];
    // block buffer as 16 big-endian words, byte 0 in bits 31:24 of word 0
    word_t blk_reg [16];
    word_t w_reg [16];
    word_t v_reg [8];
    logic [COUNT_W-1:0] count_reg;
    logic [5:0] rnd_reg;
    logic [2:0] out_idx_reg;
    // eom_reg: message end seen, padding or output follows; len_pending_reg: second
    // pad block (length only) still to go; pad_done_reg: padding has started
    logic eom_reg, len_pending_reg, pad_done_reg;

    word_t wv, w15, w2, new_a, new_e;
    word_t pad_blk [16];
    logic [5:0] fill;
    logic [63:0] bit_len;

    assign fill = count_reg[5:0];
    assign bit_len = {count_reg, 3'b000};
    assign w15 = w_reg[4'(rnd_reg + 6'd1)];
    assign w2  = w_reg[4'(rnd_reg + 6'd14)];

    always_comb
    begin
        if (rnd_reg < 6'd16)
            wv = blk_reg[rnd_reg[3:0]];
        else
            wv = w_reg[rnd_reg[3:0]]
               + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
               + w_reg[4'(rnd_reg + 6'd9)]
               + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
    end

    // Padded block: marker, zero fill and length if it fits (or zeros and length on 2nd block)
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            pad_blk[i] = blk_reg[i];
            for (int j = 0; j < 4; j++)
            begin
                if (!len_pending_reg && (4*i + j) == int'(fill))
                    pad_blk[i][8*(3-j) +: 8] = 8'h80;
                else if (len_pending_reg || (4*i + j) > int'(fill))
                    pad_blk[i][8*(3-j) +: 8] = 8'h00;
            end
        end
        if (len_pending_reg || fill < 6'd56)
        begin
            pad_blk[14] = bit_len[63:32];
            pad_blk[15] = bit_len[31:0];
        end
    end

    sha256_round u_round (
        .a(v_reg[0]), .b(v_reg[1]), .c(v_reg[2]), .d(v_reg[3]),
        .e(v_reg[4]), .f(v_reg[5]), .g(v_reg[6]), .h(v_reg[7]),
        .wv(wv), .r(rnd_reg), .new_a(new_a), .new_e(new_e)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = (state_reg == ST_OUT);
    assign rsp.payload.digest_word = hash_reg[out_idx_reg];
    assign rsp.payload.word_index = out_idx_reg;
    assign rsp.payload.last_word = (out_idx_reg == 3'd7);

    logic req_fire;
    assign req_fire = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.payload.has_byte && (fill == 6'd63))
                        state_next = ST_ROUND;
                    else if (req.payload.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND: if (rnd_reg == 6'd63) state_next = ST_FOLD;
            ST_FOLD:
            begin
                // a full data block with the end mark still needs its padding
                if (len_pending_reg || (eom_reg && !pad_done_reg)) state_next = ST_PAD;
                else if (eom_reg) state_next = ST_OUT;
                else state_next = ST_IDLE;
            end
            ST_PAD: state_next = ST_ROUND;
            ST_OUT: if (rsp.ready && out_idx_reg == 3'd7) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rnd_reg <= '0;
            out_idx_reg <= '0;
            eom_reg <= 1'b0;
            len_pending_reg <= 1'b0;
            pad_done_reg <= 1'b0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= init_hash(3'(i));
            for (int i = 0; i < 16; i++) blk_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        eom_reg <= req.payload.end_of_message;
                        if (req.payload.has_byte)
                        begin
                            blk_reg[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <=
                                req.payload.data_byte;
                            count_reg <= count_reg + 1'b1;
                        end
                        for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
                    end
                end
                ST_PAD:
                begin
                    for (int i = 0; i < 16; i++) blk_reg[i] <= pad_blk[i];
                    if (len_pending_reg || fill < 6'd56)
                        len_pending_reg <= 1'b0;
                    else
                        len_pending_reg <= 1'b1;
                    pad_done_reg <= 1'b1;
                    for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
                end
                ST_ROUND:
                begin
                    w_reg[rnd_reg[3:0]] <= wv;
                    v_reg[0] <= new_a; v_reg[1] <= v_reg[0];
                    v_reg[2] <= v_reg[1]; v_reg[3] <= v_reg[2];
                    v_reg[4] <= new_e; v_reg[5] <= v_reg[4];
                    v_reg[6] <= v_reg[5]; v_reg[7] <= v_reg[6];
                    rnd_reg <= rnd_reg + 1'b1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + v_reg[i];
                    for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i] + v_reg[i];
                end
                ST_OUT:
                begin
                    if (rsp.ready)
                    begin
                        out_idx_reg <= out_idx_reg + 1'b1;
                        if (out_idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++) hash_reg[i] <= init_hash(3'(i));
                            for (int i = 0; i < 16; i++) blk_reg[i] <= '0;
                            count_reg <= '0;
                            eom_reg <= 1'b0;
                            pad_done_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_round_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> rnd_reg == 6'd0) else $error("round count not zero");
    a_fold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FOLD |-> $past(rnd_reg) == 6'd63) else $error("fold early");
    a_out_has_eom: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> eom_reg) else $error("digest without end mark");
    a_out_padded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> pad_done_reg) else $error("digest without padding");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
`endif
endmodule
